// File: rtl/core/i2c_register_access_master_top_assert.svh
// Assertion macros shared by the I2C register access master checkers.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define I2CRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2crm check failed");

// Next-cycle implication, off during reset.
`define I2CRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2crm check failed");

`endif

// File: rtl/core/i2crm_pkg.sv
// Package for the I2C register access master: operation codes, register
// indexes, reset values and the result type. No dependencies.
package i2crm_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_PHASE_TICKS    = 2'd1,
        CFG_ACK_TIMEOUT    = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_index;

    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd104;
    localparam logic [7:0] PHASE_TICKS_RST    = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack_error;
    } t_result;

endpackage

// File: rtl/core/i2c_register_access_master_top.sv
// I2C register access master: bus sequencer, one tick per input transfer.
// Depends on i2crm_pkg; checked by i2crm_checker (bound from its own file).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | operation, reg_address, write_data,
//          |           |                           | sda_in
//  out     | output    | o_out_valid / i_out_stall | scl_out, sda_out, busy_res, done_res,
//          |           |                           | read_data, ack_error
//  cfg     | input     | i_cfg_we (no handshake)   | i_cfg_index, i_cfg_data
//
// One input transfer is taken per clock while o_in_stall is low; its result is
// registered in the output register or skid. The sequencer state advances in the
// same cycle the tick is taken. Reset (i_rst_n low, synchronous) returns the
// sequencer to idle and the registers to their defaults. A stalled output holds
// in the output register; a second result goes to a skid register, and
// o_in_stall is high while the skid register is full.
module i2c_register_access_master_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_operation,
    input  logic [7:0]                     i_reg_address,
    input  logic [7:0]                     i_write_data,
    input  logic                           i_sda_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_scl_out,
    output logic                           o_sda_out,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [7:0]                     o_read_data,
    output logic                           o_ack_error,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [i2crm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import i2crm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'd0,
        ST_DONE      = 5'd1,
        ST_START_A   = 5'd2,
        ST_START_B   = 5'd3,
        ST_START_C   = 5'd4,
        ST_TX_LOW    = 5'd5,
        ST_TX_HIGH   = 5'd6,
        ST_ACK_LOW   = 5'd7,
        ST_ACK_HIGH  = 5'd8,
        ST_ACK_END   = 5'd9,
        ST_RX_LOW    = 5'd10,
        ST_RX_HIGH   = 5'd11,
        ST_NACK_LOW  = 5'd12,
        ST_NACK_HIGH = 5'd13,
        ST_STOP_A    = 5'd14,
        ST_STOP_B    = 5'd15,
        ST_STOP_C    = 5'd16
    } t_state;

    localparam logic [1:0] STAGE_ADDR = 2'd0;
    localparam logic [1:0] STAGE_REG  = 2'd1;
    localparam logic [1:0] STAGE_DATA = 2'd2;

    // configuration
    logic [6:0] r_device_address;
    logic [7:0] r_phase_ticks;
    logic [7:0] r_ack_timeout;

    // sequencer
    t_state     r_state,      n_state;
    logic [2:0] r_bit_cnt,    n_bit_cnt;
    logic [7:0] r_shift,      n_shift;
    logic [7:0] r_phase_cnt,  n_phase_cnt;
    logic [7:0] r_wait_cnt,   n_wait_cnt;
    logic       r_is_read,    n_is_read;
    logic [7:0] r_held_reg,   n_held_reg;
    logic [7:0] r_held_data,  n_held_data;
    logic       r_error,      n_error;
    logic [1:0] r_stage,      n_stage;
    logic [7:0] r_last_read,  n_last_read;

    // output register and skid
    logic       r_o_valid;
    logic       r_s_valid;
    t_result    r_o_res;
    t_result    r_s_res;
    t_result    cur_res;

    logic       in_acc;
    logic       out_free;
    logic       phase_done;
    logic [7:0] phase_len;
    logic [6:0] addr_hi;

    assign in_acc   = i_in_valid && !r_s_valid;
    assign out_free = !r_o_valid || !i_out_stall;

    // zero length counts as one tick
    assign phase_len  = (r_phase_ticks == 8'd0) ? 8'd1 : r_phase_ticks;
    assign phase_done = ({1'b0, r_phase_cnt} + 9'd1) >= {1'b0, phase_len};
    assign addr_hi    = r_device_address;

    // result from the state at the start of the tick
    always_comb begin
        cur_res.scl       = 1'b1;
        cur_res.sda       = 1'b1;
        cur_res.busy      = 1'b1;
        cur_res.done      = 1'b0;
        cur_res.read_data = r_last_read;
        cur_res.ack_error = r_error;
        unique case (r_state)
            ST_START_B, ST_STOP_B: cur_res.sda = 1'b0;
            ST_START_C, ST_STOP_A: begin
                cur_res.scl = 1'b0;
                cur_res.sda = 1'b0;
            end
            ST_TX_LOW: begin
                cur_res.scl = 1'b0;
                cur_res.sda = r_shift[7];
            end
            ST_TX_HIGH: cur_res.sda = r_shift[7];
            ST_ACK_LOW, ST_ACK_END, ST_RX_LOW, ST_NACK_LOW: cur_res.scl = 1'b0;
            ST_IDLE: cur_res.busy = 1'b0;
            ST_DONE: begin
                cur_res.busy = 1'b0;
                cur_res.done = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_wait_cnt  = r_wait_cnt;
        n_is_read   = r_is_read;
        n_held_reg  = r_held_reg;
        n_held_data = r_held_data;
        n_error     = r_error;
        n_stage     = r_stage;
        n_last_read = r_last_read;
        n_phase_cnt = r_phase_cnt;
        // phase counter advances in every timed state; overridden below
        if (phase_done) begin
            n_phase_cnt = 8'd0;
        end else begin
            n_phase_cnt = r_phase_cnt + 8'd1;
        end

        unique case (r_state)
            ST_IDLE, ST_DONE: begin
                n_phase_cnt = r_phase_cnt;
                if (i_operation == OP_WRITE || i_operation == OP_READ) begin
                    n_is_read   = (i_operation == OP_READ);
                    n_held_reg  = i_reg_address;
                    n_held_data = i_write_data;
                    n_error     = 1'b0;
                    n_stage     = STAGE_ADDR;
                    n_bit_cnt   = 3'd0;
                    n_phase_cnt = 8'd0;
                    n_wait_cnt  = 8'd0;
                    n_state     = ST_START_A;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_START_A: if (phase_done) n_state = ST_START_B;
            ST_START_B: if (phase_done) n_state = ST_START_C;
            ST_START_C: begin
                if (phase_done) begin
                    n_shift   = {addr_hi, (r_stage >= STAGE_DATA)};
                    n_bit_cnt = 3'd0;
                    n_state   = ST_TX_LOW;
                end
            end
            ST_TX_LOW: if (phase_done) n_state = ST_TX_HIGH;
            ST_TX_HIGH: begin
                if (phase_done) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt = 3'd0;
                        n_state   = ST_ACK_LOW;
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                        n_state   = ST_TX_LOW;
                    end
                end
            end
            ST_ACK_LOW: begin
                if (phase_done) begin
                    n_wait_cnt = 8'd0;
                    n_state    = ST_ACK_HIGH;
                end
            end
            ST_ACK_HIGH: begin
                n_phase_cnt = r_phase_cnt;
                if (!i_sda_in) begin
                    n_phase_cnt = 8'd0;
                    n_state     = ST_ACK_END;
                end else if (r_wait_cnt >= r_ack_timeout) begin
                    // timeout: flag and abort through STOP
                    n_error     = 1'b1;
                    n_phase_cnt = 8'd0;
                    n_state     = ST_STOP_A;
                end else begin
                    n_wait_cnt = r_wait_cnt + 8'd1;
                end
            end
            ST_ACK_END: begin
                if (phase_done) begin
                    priority if (r_stage == STAGE_ADDR) begin
                        n_stage   = STAGE_REG;
                        n_shift   = r_held_reg;
                        n_bit_cnt = 3'd0;
                        n_state   = ST_TX_LOW;
                    end else if (r_stage == STAGE_REG) begin
                        n_stage = STAGE_DATA;
                        if (r_is_read) begin
                            n_state = ST_START_A;
                        end else begin
                            n_shift   = r_held_data;
                            n_bit_cnt = 3'd0;
                            n_state   = ST_TX_LOW;
                        end
                    end else if (r_is_read) begin
                        n_shift   = 8'd0;
                        n_bit_cnt = 3'd0;
                        n_state   = ST_RX_LOW;
                    end else begin
                        n_state = ST_STOP_A;
                    end
                end
            end
            ST_RX_LOW: if (phase_done) n_state = ST_RX_HIGH;
            ST_RX_HIGH: begin
                if (phase_done) begin
                    n_shift = {r_shift[6:0], i_sda_in};
                    if (r_bit_cnt == 3'd7) begin
                        n_bit_cnt   = 3'd0;
                        n_last_read = {r_shift[6:0], i_sda_in};
                        n_state     = ST_NACK_LOW;
                    end else begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                        n_state   = ST_RX_LOW;
                    end
                end
            end
            ST_NACK_LOW:  if (phase_done) n_state = ST_NACK_HIGH;
            ST_NACK_HIGH: if (phase_done) n_state = ST_STOP_A;
            ST_STOP_A:    if (phase_done) n_state = ST_STOP_B;
            ST_STOP_B:    if (phase_done) n_state = ST_STOP_C;
            ST_STOP_C:    if (phase_done) n_state = ST_DONE;
            default: begin
                n_phase_cnt = r_phase_cnt;
                n_state     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= DEVICE_ADDRESS_RST;
            r_phase_ticks    <= PHASE_TICKS_RST;
            r_ack_timeout    <= ACK_TIMEOUT_RST;
            r_state          <= ST_IDLE;
            r_bit_cnt        <= 3'd0;
            r_shift          <= 8'd0;
            r_phase_cnt      <= 8'd0;
            r_wait_cnt       <= 8'd0;
            r_is_read        <= 1'b0;
            r_held_reg       <= 8'd0;
            r_held_data      <= 8'd0;
            r_error          <= 1'b0;
            r_stage          <= STAGE_ADDR;
            r_last_read      <= 8'd0;
            r_o_valid        <= 1'b0;
            r_s_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data[6:0];
                    CFG_PHASE_TICKS:    r_phase_ticks    <= i_cfg_data;
                    CFG_ACK_TIMEOUT:    r_ack_timeout    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_state     <= n_state;
                r_bit_cnt   <= n_bit_cnt;
                r_shift     <= n_shift;
                r_phase_cnt <= n_phase_cnt;
                r_wait_cnt  <= n_wait_cnt;
                r_is_read   <= n_is_read;
                r_held_reg  <= n_held_reg;
                r_held_data <= n_held_data;
                r_error     <= n_error;
                r_stage     <= n_stage;
                r_last_read <= n_last_read;
            end
            // output register refills from skid first, then from the new transfer
            if (out_free) begin
                if (r_s_valid) begin
                    r_o_res   <= r_s_res;
                    r_o_valid <= 1'b1;
                    r_s_valid <= 1'b0;
                end else if (in_acc) begin
                    r_o_res   <= cur_res;
                    r_o_valid <= 1'b1;
                end else begin
                    r_o_valid <= 1'b0;
                end
            end else if (in_acc) begin
                r_s_res   <= cur_res;
                r_s_valid <= 1'b1;
            end
        end
    end

    assign o_in_stall  = r_s_valid;
    assign o_out_valid = r_o_valid;
    assign o_scl_out   = r_o_res.scl;
    assign o_sda_out   = r_o_res.sda;
    assign o_busy_res  = r_o_res.busy;
    assign o_done_res  = r_o_res.done;
    assign o_read_data = r_o_res.read_data;
    assign o_ack_error = r_o_res.ack_error;

endmodule

// File: rtl/core/i2crm_checker.sv
// Port-level checks for i2c_register_access_master_top, attached by bind.
// Depends on i2c_register_access_master_top_assert.svh for the macros.
`include "i2c_register_access_master_top_assert.svh"

module i2crm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_read_data
);

    // skid full only behind a full output register
    `I2CRM_ASSERT_NOW(a_skid_behind_out, o_in_stall, o_out_valid)

    // after every accepted tick the output register holds a result
    `I2CRM_ASSERT_NEXT(a_accept_gives_result, i_in_valid && !o_in_stall, o_out_valid)

    // the done tick follows STOP: lines released, not busy
    `I2CRM_ASSERT_NOW(a_done_after_stop, o_out_valid && o_done_res,
        o_scl_out && o_sda_out && !o_busy_res)

    // a stalled result holds
    `I2CRM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_scl_out) && $stable(o_sda_out) && $stable(o_read_data))

endmodule

bind i2c_register_access_master_top i2crm_checker u_i2crm_checker (.*);

// File: dv/i2crm_bus_checker.sv
// Checker for the I2C register access master: tracks register writes, predicts
// the bus drive for every tick taken and compares it with each result transfer.
// Depends on i2crm_pkg for the operation codes, register indexes and result type.
module i2crm_bus_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_operation,
    input  logic [7:0]                       i_reg_address,
    input  logic [7:0]                       i_write_data,
    input  logic                             i_sda_in,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_scl_out,
    input  logic                             i_sda_out,
    input  logic                             i_busy_res,
    input  logic                             i_done_res,
    input  logic [7:0]                       i_read_data,
    input  logic                             i_ack_error,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [i2crm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned                      o_fail_count,
    output int unsigned                      o_pending,
    output int unsigned                      o_checked
);
    import i2crm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DONE, S_START_A, S_START_B, S_START_C, S_TX_LOW, S_TX_HIGH,
        S_ACK_LOW, S_ACK_HIGH, S_ACK_END, S_RX_LOW, S_RX_HIGH, S_NACK_LOW,
        S_NACK_HIGH, S_STOP_A, S_STOP_B, S_STOP_C
    } t_bus_step;

    // register copies
    logic [6:0] dev_addr;
    logic [7:0] half_len_cfg;
    logic [7:0] ack_limit;

    // sequencer copy
    t_bus_step  step;
    logic [2:0] bit_idx;
    logic [7:0] shreg;
    logic [7:0] phase_cnt;
    logic [7:0] wait_cnt;
    logic       rd_mode;
    logic [7:0] reg_hold;
    logic [7:0] data_hold;
    logic       err;
    logic [1:0] stage;
    logic [7:0] rx_byte;

    t_result     expected_bus[$];
    t_result     next_drive;
    t_result     seen_drive;
    int unsigned fails;
    int unsigned checked;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    initial begin
        fails   = 0;
        checked = 0;
    end

    task automatic report_failure(input string msg);
        $display("checker: %s", msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_failure($sformatf("result %0d field %s: got %0d, want %0d",
                                     checked, name, got, want));
        end
    endtask

    task automatic clear_sequencer();
        dev_addr     = DEVICE_ADDRESS_RST;
        half_len_cfg = PHASE_TICKS_RST;
        ack_limit    = ACK_TIMEOUT_RST;
        step         = S_IDLE;
        bit_idx      = '0;
        shreg        = '0;
        phase_cnt    = '0;
        wait_cnt     = '0;
        rd_mode      = 1'b0;
        reg_hold     = '0;
        data_hold    = '0;
        err          = 1'b0;
        stage        = '0;
        rx_byte      = '0;
    endtask

    // Advance the half-phase count; true on the last tick of the half phase.
    function automatic logic half_phase_over();
        int len;
        len = (half_len_cfg == 8'd0) ? 1 : int'(half_len_cfg);
        if (int'(phase_cnt) + 1 >= len) begin
            phase_cnt = '0;
            return 1'b1;
        end
        phase_cnt = phase_cnt + 8'd1;
        return 1'b0;
    endfunction

    task automatic load_byte(input logic [7:0] value);
        shreg     = value;
        bit_idx   = '0;
        phase_cnt = '0;
        step      = S_TX_LOW;
    endtask

    // Drive comes from the state at the start of the tick, then the tick advances it.
    task automatic predict_tick(input t_op op, input logic [7:0] reg_addr,
                                input logic [7:0] wr_data, input logic sda,
                                output t_result drive);
        drive.scl       = 1'b1;
        drive.sda       = 1'b1;
        drive.busy      = 1'b1;
        drive.done      = 1'b0;
        drive.read_data = rx_byte;
        drive.ack_error = err;
        case (step)
            S_START_B, S_STOP_B: drive.sda = 1'b0;
            S_START_C, S_STOP_A: begin
                drive.scl = 1'b0;
                drive.sda = 1'b0;
            end
            S_TX_LOW: begin
                drive.scl = 1'b0;
                drive.sda = shreg[7];
            end
            S_TX_HIGH: drive.sda = shreg[7];
            S_ACK_LOW, S_ACK_END, S_RX_LOW, S_NACK_LOW: drive.scl = 1'b0;
            S_IDLE: drive.busy = 1'b0;
            S_DONE: begin
                drive.busy = 1'b0;
                drive.done = 1'b1;
            end
            default: ;
        endcase

        case (step)
            S_IDLE, S_DONE: begin
                if (op == OP_WRITE || op == OP_READ) begin
                    rd_mode   = (op == OP_READ);
                    reg_hold  = reg_addr;
                    data_hold = wr_data;
                    err       = 1'b0;
                    stage     = '0;
                    bit_idx   = '0;
                    phase_cnt = '0;
                    wait_cnt  = '0;
                    step      = S_START_A;
                end else begin
                    step = S_IDLE;
                end
            end
            S_START_A: if (half_phase_over()) step = S_START_B;
            S_START_B: if (half_phase_over()) step = S_START_C;
            S_START_C: begin
                // address byte; the read bit is set after the repeated START
                if (half_phase_over()) load_byte({dev_addr, stage >= 2'd2});
            end
            S_TX_LOW: if (half_phase_over()) step = S_TX_HIGH;
            S_TX_HIGH: begin
                if (half_phase_over()) begin
                    shreg = {shreg[6:0], 1'b0};
                    if (bit_idx == 3'd7) begin
                        bit_idx = '0;
                        step    = S_ACK_LOW;
                    end else begin
                        bit_idx = bit_idx + 3'd1;
                        step    = S_TX_LOW;
                    end
                end
            end
            S_ACK_LOW: begin
                if (half_phase_over()) begin
                    wait_cnt = '0;
                    step     = S_ACK_HIGH;
                end
            end
            S_ACK_HIGH: begin
                if (!sda) begin
                    phase_cnt = '0;
                    step      = S_ACK_END;
                end else if (wait_cnt >= ack_limit) begin
                    err       = 1'b1;
                    phase_cnt = '0;
                    step      = S_STOP_A;
                end else begin
                    wait_cnt = wait_cnt + 8'd1;
                end
            end
            S_ACK_END: begin
                if (half_phase_over()) begin
                    if (stage == 2'd0) begin
                        stage = 2'd1;
                        load_byte(reg_hold);
                    end else if (stage == 2'd1) begin
                        stage = 2'd2;
                        if (rd_mode) step = S_START_A;
                        else load_byte(data_hold);
                    end else if (rd_mode) begin
                        shreg   = '0;
                        bit_idx = '0;
                        step    = S_RX_LOW;
                    end else begin
                        step = S_STOP_A;
                    end
                end
            end
            S_RX_LOW: if (half_phase_over()) step = S_RX_HIGH;
            S_RX_HIGH: begin
                if (half_phase_over()) begin
                    shreg = {shreg[6:0], sda};
                    if (bit_idx == 3'd7) begin
                        bit_idx = '0;
                        rx_byte = shreg;
                        step    = S_NACK_LOW;
                    end else begin
                        bit_idx = bit_idx + 3'd1;
                        step    = S_RX_LOW;
                    end
                end
            end
            S_NACK_LOW:  if (half_phase_over()) step = S_NACK_HIGH;
            S_NACK_HIGH: if (half_phase_over()) step = S_STOP_A;
            S_STOP_A:    if (half_phase_over()) step = S_STOP_B;
            S_STOP_B:    if (half_phase_over()) step = S_STOP_C;
            S_STOP_C:    if (half_phase_over()) step = S_DONE;
            default:     step = S_IDLE;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sequencer();
            expected_bus.delete();
        end else begin
            // compare before queuing this edge's tick: its result comes later
            if (i_out_valid && !i_out_stall) begin
                if (expected_bus.size() == 0) begin
                    report_failure("result transfer with nothing expected");
                end else begin
                    next_drive          = expected_bus.pop_front();
                    seen_drive.scl       = i_scl_out;
                    seen_drive.sda       = i_sda_out;
                    seen_drive.busy      = i_busy_res;
                    seen_drive.done      = i_done_res;
                    seen_drive.read_data = i_read_data;
                    seen_drive.ack_error = i_ack_error;
                    check_field("scl_out", seen_drive.scl, next_drive.scl);
                    check_field("sda_out", seen_drive.sda, next_drive.sda);
                    check_field("busy_res", seen_drive.busy, next_drive.busy);
                    check_field("done_res", seen_drive.done, next_drive.done);
                    check_field("read_data", seen_drive.read_data, next_drive.read_data);
                    check_field("ack_error", seen_drive.ack_error, next_drive.ack_error);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_tick(t_op'(i_operation), i_reg_address, i_write_data,
                             i_sda_in, next_drive);
                expected_bus.push_back(next_drive);
            end
            // a register write lands at the edge, after this edge's tick
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_DEVICE_ADDRESS: dev_addr     = i_cfg_data[6:0];
                    CFG_PHASE_TICKS:    half_len_cfg = i_cfg_data;
                    CFG_ACK_TIMEOUT:    ack_limit    = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_bus.size();
    end

endmodule

// File: dv/tb.sv
// Top of the I2C register access master testbench: clock, reset, tick and
// register stimulus, verdict. Depends on i2crm_pkg, the block and i2crm_bus_checker.
module tb;
    import i2crm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 40000;
    localparam int unsigned QUIET_FROM  = 800;
    localparam int unsigned QUIET_TO    = 1800;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [1:0]            operation   = OP_TICK;
    logic [7:0]            reg_address = '0;
    logic [7:0]            write_data  = '0;
    logic                  sda_in      = 1'b1;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  scl_out;
    logic                  sda_out;
    logic                  busy_res;
    logic                  done_res;
    logic [7:0]            read_data;
    logic                  ack_error;
    logic                  cfg_we      = 1'b0;
    logic [1:0]            cfg_index   = CFG_DEVICE_ADDRESS;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int unsigned fail_count;
    int unsigned results_pending;
    int unsigned results_checked;
    int unsigned cycle_count  = 0;
    int unsigned ticks_sent   = 0;
    int unsigned settings     = 0;
    int unsigned sda_high_pct = 0;
    logic        last_busy    = 1'b0;

    i2c_register_access_master_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_reg_address (reg_address),
        .i_write_data  (write_data),
        .i_sda_in      (sda_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_scl_out     (scl_out),
        .o_sda_out     (sda_out),
        .o_busy_res    (busy_res),
        .o_done_res    (done_res),
        .o_read_data   (read_data),
        .o_ack_error   (ack_error),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    i2crm_bus_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_operation   (operation),
        .i_reg_address (reg_address),
        .i_write_data  (write_data),
        .i_sda_in      (sda_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_scl_out     (scl_out),
        .i_sda_out     (sda_out),
        .i_busy_res    (busy_res),
        .i_done_res    (done_res),
        .i_read_data   (read_data),
        .i_ack_error   (ack_error),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (results_pending),
        .o_checked     (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Random gaps and stalls, except inside one long quiet window.
    function automatic bit take_break();
        if (cycle_count >= QUIET_FROM && cycle_count <= QUIET_TO) return 1'b0;
        return $urandom_range(99) < 8;
    endfunction

    function automatic logic pick_sda();
        return $urandom_range(99) < sda_high_pct;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        out_stall   <= take_break();
        if (out_valid && !out_stall) last_busy <= busy_res;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_tick(input t_op op, input logic [7:0] ra, input logic [7:0] wd,
                             input logic sda);
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        reg_address <= ra;
        write_data  <= wd;
        sda_in      <= sda;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Tick the sequencer until it is back in idle and every result is in.
    // Noise operations go only early in a batch so the batch ends on plain ticks.
    task automatic settle(input bit noisy);
        do begin
            for (int i = 0; i < 16; i++) begin
                if (noisy && i < 12 && $urandom_range(99) < 10)
                    send_tick(t_op'($urandom_range(3)), 8'($urandom), 8'($urandom),
                              pick_sda());
                else
                    send_tick(OP_TICK, 8'($urandom), 8'($urandom), pick_sda());
            end
            in_valid <= 1'b0;
            do @(posedge i_clk); while (results_pending != 0);
        end while (last_busy);
    endtask

    task automatic run_transfer(input t_op op, input logic [7:0] ra, input logic [7:0] wd);
        send_tick(op, ra, wd, pick_sda());
        settle(1'b1);
    endtask

    task automatic program_registers(input logic [6:0] addr, input logic [7:0] phase,
                                     input logic [7:0] timeout);
        repeat (2) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEVICE_ADDRESS;
        cfg_data  <= {1'($urandom_range(1)), addr};
        @(posedge i_clk);
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= phase;
        @(posedge i_clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data  <= timeout;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_phase(input int unsigned count);
        int unsigned first;
        first = ticks_sent;
        while (ticks_sent - first < count) begin
            if ($urandom_range(99) < 85) begin
                run_transfer($urandom_range(1) ? OP_READ : OP_WRITE,
                             8'($urandom), 8'($urandom));
            end else begin
                send_tick(t_op'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          pick_sda());
                settle(1'b1);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: clean writes, reads, spare code, ACK timeout with SDA stuck high
        sda_high_pct = 0;
        run_transfer(OP_WRITE, 8'h00, 8'hFF);
        run_transfer(OP_WRITE, 8'hFF, 8'h00);
        sda_high_pct = 50;
        run_transfer(OP_READ, 8'hA5, 8'h5A);
        sda_high_pct = 20;
        run_transfer(OP_READ, 8'h3C, 8'hC3);
        send_tick(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
        settle(1'b0);
        sda_high_pct = 100;
        run_transfer(OP_READ, 8'h81, 8'h7E);
        run_transfer(OP_WRITE, 8'h7E, 8'h81);
        sda_high_pct = 0;
        run_transfer(OP_READ, 8'h01, 8'h80);

        // exercise the unused index once; then shortest phase, timeout one, address zero
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'hFF;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        program_registers(7'h00, 8'd1, 8'd1);
        sda_high_pct = 50;
        random_phase(80);

        // longest timeout at a short phase: one clean write, one read aborted at the ACK timeout
        program_registers(7'h7F, 8'd3, 8'd255);
        sda_high_pct = 0;
        run_transfer(OP_WRITE, 8'hC3, 8'h3C);
        sda_high_pct = 100;
        run_transfer(OP_READ, 8'h5A, 8'hA5);

        // zero phase length and zero timeout
        program_registers(7'($urandom), 8'd0, 8'd0);
        sda_high_pct = 50;
        random_phase(80);

        repeat (4) begin
            program_registers(7'($urandom), 8'($urandom_range(1, 4)),
                              ($urandom_range(3) == 0) ? 8'd250 : 8'($urandom_range(5)));
            sda_high_pct = ($urandom_range(1) == 0) ? 10 : 10 + 20 * $urandom_range(2);
            random_phase(60);
        end

        in_valid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
        repeat (4) @(posedge i_clk);

        $display("sent %0d bus ticks under %0d register settings", ticks_sent, settings + 1);
        $display("compared %0d results, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/i2crm_pkg.sv
rtl/core/i2c_register_access_master_top.sv
rtl/core/i2crm_checker.sv
dv/i2crm_bus_checker.sv
dv/tb.sv
